### design/assert_macros.svh
// Assertion helpers included by the decoder top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("same-cycle property failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("next-cycle property failed");

`endif

### design/ocd_pkg.sv
// ----------------------------------------------------------------------------
// Opcode decoder package
// Types, decode table and helper functions of the 8-bit CPU opcode decoder.
// ----------------------------------------------------------------------------
package ocd_pkg;

  localparam int unsigned OP_W    = 8;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned LEN_W   = 2;
  localparam int unsigned CLASS_W = 6;
  localparam int unsigned ROM_DEPTH = 1 << OP_W;

  typedef enum logic [MODE_W-1:0] {
    AM_IMP    = 4'd0,
    AM_ACC    = 4'd1,
    AM_IMM    = 4'd2,
    AM_ABS    = 4'd3,
    AM_ABSX   = 4'd4,
    AM_ABSY   = 4'd5,
    AM_ZP     = 4'd6,
    AM_ZPX    = 4'd7,
    AM_ZPY    = 4'd8,
    AM_REL    = 4'd9,
    AM_IND    = 4'd10,
    AM_IDXIND = 4'd11,
    AM_INDIDX = 4'd12
  } addr_mode_t;

  typedef enum logic [CLASS_W-1:0] {
    OC_ILL  = 6'd0,  OC_LDA  = 6'd1,  OC_LDX  = 6'd2,  OC_LDY  = 6'd3,
    OC_LAX  = 6'd4,  OC_STA  = 6'd5,  OC_STX  = 6'd6,  OC_STY  = 6'd7,
    OC_ADC  = 6'd8,  OC_SBC  = 6'd9,  OC_INC  = 6'd10, OC_INX  = 6'd11,
    OC_INY  = 6'd12, OC_DEC  = 6'd13, OC_DEX  = 6'd14, OC_DEY  = 6'd15,
    OC_ASLM = 6'd16, OC_ASLA = 6'd17, OC_LSRM = 6'd18, OC_LSRA = 6'd19,
    OC_ROLM = 6'd20, OC_ROLA = 6'd21, OC_RORM = 6'd22, OC_RORA = 6'd23,
    OC_AND  = 6'd24, OC_ORA  = 6'd25, OC_EOR  = 6'd26, OC_CMP  = 6'd27,
    OC_CPX  = 6'd28, OC_CPY  = 6'd29, OC_BIT  = 6'd30, OC_BPL  = 6'd31,
    OC_BVC  = 6'd32, OC_BCC  = 6'd33, OC_BNE  = 6'd34, OC_BMI  = 6'd35,
    OC_BVS  = 6'd36, OC_BCS  = 6'd37, OC_BEQ  = 6'd38, OC_TAX  = 6'd39,
    OC_TAY  = 6'd40, OC_TSX  = 6'd41, OC_TXA  = 6'd42, OC_TXS  = 6'd43,
    OC_TYA  = 6'd44, OC_JMP  = 6'd45, OC_JSR  = 6'd46, OC_RTS  = 6'd47,
    OC_RTI  = 6'd48, OC_PHA  = 6'd49, OC_PLA  = 6'd50, OC_PHP  = 6'd51,
    OC_PLP  = 6'd52, OC_BRK  = 6'd53, OC_CLC  = 6'd54, OC_CLI  = 6'd55,
    OC_CLV  = 6'd56, OC_CLD  = 6'd57, OC_SEC  = 6'd58, OC_SEI  = 6'd59,
    OC_SED  = 6'd60, OC_NOP  = 6'd61
  } op_class_t;

  typedef struct packed {
    addr_mode_t       mode;
    logic [LEN_W-1:0] len;
    op_class_t        cls;
    logic             illegal;
  } decode_word_t;

  // Operation class of every opcode, indexed by the opcode byte.
  localparam op_class_t OP_TAB [ROM_DEPTH] = '{
    OC_BRK, OC_ORA, OC_ILL, OC_ILL, OC_NOP, OC_ORA, OC_ASLM, OC_ILL,
    OC_PHP, OC_ORA, OC_ASLA, OC_ILL, OC_NOP, OC_ORA, OC_ASLM, OC_ILL,
    OC_BPL, OC_ORA, OC_ILL, OC_ILL, OC_NOP, OC_ORA, OC_ASLM, OC_ILL,
    OC_CLC, OC_ORA, OC_NOP, OC_ILL, OC_NOP, OC_ORA, OC_ASLM, OC_ILL,
    OC_JSR, OC_AND, OC_ILL, OC_ILL, OC_BIT, OC_AND, OC_ROLM, OC_ILL,
    OC_PLP, OC_AND, OC_ROLA, OC_ILL, OC_BIT, OC_AND, OC_ROLM, OC_ILL,
    OC_BMI, OC_AND, OC_ILL, OC_ILL, OC_NOP, OC_AND, OC_ROLM, OC_ILL,
    OC_SEC, OC_AND, OC_NOP, OC_ILL, OC_NOP, OC_AND, OC_ROLM, OC_ILL,
    OC_RTI, OC_EOR, OC_ILL, OC_ILL, OC_NOP, OC_EOR, OC_LSRM, OC_ILL,
    OC_PHA, OC_EOR, OC_LSRA, OC_ILL, OC_JMP, OC_EOR, OC_LSRM, OC_ILL,
    OC_BVC, OC_EOR, OC_ILL, OC_ILL, OC_NOP, OC_EOR, OC_LSRM, OC_ILL,
    OC_CLI, OC_EOR, OC_NOP, OC_ILL, OC_NOP, OC_EOR, OC_LSRM, OC_ILL,
    OC_RTS, OC_ADC, OC_ILL, OC_ILL, OC_NOP, OC_ADC, OC_RORM, OC_ILL,
    OC_PLA, OC_ADC, OC_RORA, OC_ILL, OC_JMP, OC_ADC, OC_RORM, OC_ILL,
    OC_BVS, OC_ADC, OC_ILL, OC_ILL, OC_NOP, OC_ADC, OC_RORM, OC_ILL,
    OC_SEI, OC_ADC, OC_NOP, OC_ILL, OC_NOP, OC_ADC, OC_RORM, OC_ILL,
    OC_NOP, OC_STA, OC_ILL, OC_ILL, OC_STY, OC_STA, OC_STX, OC_ILL,
    OC_DEY, OC_ILL, OC_TXA, OC_ILL, OC_STY, OC_STA, OC_STX, OC_ILL,
    OC_BCC, OC_STA, OC_ILL, OC_ILL, OC_STY, OC_STA, OC_STX, OC_ILL,
    OC_TYA, OC_STA, OC_TXS, OC_ILL, OC_ILL, OC_STA, OC_ILL, OC_ILL,
    OC_LDY, OC_LDA, OC_LDX, OC_LAX, OC_LDY, OC_LDA, OC_LDX, OC_LAX,
    OC_TAY, OC_LDA, OC_TAX, OC_ILL, OC_LDY, OC_LDA, OC_LDX, OC_LAX,
    OC_BCS, OC_LDA, OC_ILL, OC_LAX, OC_LDY, OC_LDA, OC_LDX, OC_LAX,
    OC_CLV, OC_LDA, OC_TSX, OC_ILL, OC_LDY, OC_LDA, OC_LDX, OC_LAX,
    OC_CPY, OC_CMP, OC_ILL, OC_ILL, OC_CPY, OC_CMP, OC_DEC, OC_ILL,
    OC_INY, OC_CMP, OC_DEX, OC_ILL, OC_CPY, OC_CMP, OC_DEC, OC_ILL,
    OC_BNE, OC_CMP, OC_ILL, OC_ILL, OC_NOP, OC_CMP, OC_DEC, OC_ILL,
    OC_CLD, OC_CMP, OC_NOP, OC_ILL, OC_NOP, OC_CMP, OC_DEC, OC_ILL,
    OC_CPX, OC_SBC, OC_ILL, OC_ILL, OC_CPX, OC_SBC, OC_INC, OC_ILL,
    OC_INX, OC_SBC, OC_NOP, OC_SBC, OC_CPX, OC_SBC, OC_INC, OC_ILL,
    OC_BEQ, OC_SBC, OC_ILL, OC_ILL, OC_NOP, OC_SBC, OC_INC, OC_ILL,
    OC_SED, OC_SBC, OC_NOP, OC_ILL, OC_NOP, OC_SBC, OC_INC, OC_ILL
  };

  // Addressing mode from the column (low nibble) and row (high nibble).
  function automatic addr_mode_t decode_mode(input logic [OP_W-1:0] op);
    logic [3:0] lo;
    logic [3:0] hi;
    logic       odd;
    addr_mode_t m;
    lo  = op[3:0];
    hi  = op[7:4];
    odd = hi[0];
    case (lo)
      4'h0: begin
        if (hi == 4'h0 || hi == 4'h4 || hi == 4'h6) m = AM_IMP;
        else if (hi == 4'h2)                         m = AM_ABS;
        else                                         m = odd ? AM_REL : AM_IMM;
      end
      4'h1: m = odd ? AM_INDIDX : AM_IDXIND;
      4'h2: m = (hi == 4'hA) ? AM_IMM : AM_IMP;
      4'h3: begin
        if (hi == 4'hA)      m = AM_IDXIND;
        else if (hi == 4'hB) m = AM_INDIDX;
        else                 m = AM_IMP;
      end
      4'h4, 4'h5: m = odd ? AM_ZPX : AM_ZP;
      4'h6: begin
        if (hi == 4'h9 || hi == 4'hB) m = AM_ZPY;
        else                          m = odd ? AM_ZPX : AM_ZP;
      end
      4'h7: begin
        if (hi == 4'hA)      m = AM_ZP;
        else if (hi == 4'hB) m = AM_ZPY;
        else                 m = AM_IMP;
      end
      4'h8: m = AM_IMP;
      4'h9: begin
        if (hi == 4'h8) m = AM_IMP;
        else            m = odd ? AM_ABSY : AM_IMM;
      end
      4'hA: m = (!odd && !hi[3]) ? AM_ACC : AM_IMP;
      4'hB: m = (hi == 4'hE) ? AM_IMM : AM_IMP;
      4'hC: begin
        if (hi == 4'h6) m = AM_IND;
        else            m = odd ? AM_ABSX : AM_ABS;
      end
      4'hD: m = odd ? AM_ABSX : AM_ABS;
      4'hE: begin
        if (hi == 4'h9)      m = AM_IMP;
        else if (hi == 4'hB) m = AM_ABSY;
        else                 m = odd ? AM_ABSX : AM_ABS;
      end
      default: begin
        if (hi == 4'hA)      m = AM_ABS;
        else if (hi == 4'hB) m = AM_ABSY;
        else                 m = AM_IMP;
      end
    endcase
    return m;
  endfunction

  // Instruction length in bytes for an addressing mode.
  function automatic logic [LEN_W-1:0] mode_len(input addr_mode_t m);
    logic [LEN_W-1:0] n;
    case (m)
      AM_IMP, AM_ACC:                  n = 2'd1;
      AM_ABS, AM_ABSX, AM_ABSY, AM_IND: n = 2'd3;
      default:                         n = 2'd2;
    endcase
    return n;
  endfunction

  // Full decode word of one opcode.
  function automatic decode_word_t decode_op(input logic [OP_W-1:0] op);
    decode_word_t w;
    w.mode    = decode_mode(op);
    w.len     = mode_len(w.mode);
    w.cls     = OP_TAB[op];
    w.illegal = (w.cls == OC_ILL);
    return w;
  endfunction

endpackage

### design/ocd_if.sv
// ----------------------------------------------------------------------------
// Opcode decoder channels
// Valid/ready interfaces for the opcode and the decoded result.
// ----------------------------------------------------------------------------
interface ocd_in_if import ocd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op_byte;

  modport source (output valid, output op_byte, input ready);
  modport sink   (input valid, input op_byte, output ready);
endinterface

interface ocd_out_if import ocd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  addr_mode;
  logic [LEN_W-1:0]   instr_bytes;
  logic [CLASS_W-1:0] op_class;
  logic               is_illegal;

  modport source (output valid, output addr_mode, output instr_bytes,
                  output op_class, output is_illegal, input ready);
  modport sink   (input valid, input addr_mode, input instr_bytes,
                  input op_class, input is_illegal, output ready);
endinterface

### design/ocd_rom.sv
// ----------------------------------------------------------------------------
// Opcode decode ROM
// Synchronous 256-entry decode ROM with a registered read port.
// ----------------------------------------------------------------------------
module ocd_rom import ocd_pkg::*; (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [OP_W-1:0] rd_addr,
  output decode_word_t    rd_data
);

  decode_word_t rd_data_r;

  // Read port holds its data while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= decode_op(rd_addr);
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/opcode_decoder_8bit_cpu_top.sv
// ----------------------------------------------------------------------------
// Opcode decoder for an 8-bit CPU
// Decodes one opcode byte into addressing mode, length and operation class.
// ----------------------------------------------------------------------------
// Usage:
//   The in_chan channel carries one opcode byte per transfer. The out_chan
//   channel returns one result per opcode: addressing mode, instruction length
//   in bytes, operation class and an illegal flag, in the order the opcodes
//   were taken.
//   An opcode transferred at one clock edge is offered on out_chan right after
//   that edge. Throughput is one opcode per cycle while out_chan.ready stays
//   high, set by the single read port of the decode ROM, whose read register
//   is also the output register.
//   When the receiver stalls, the ROM read register holds the pending result
//   and in_chan.ready drops; a new opcode is taken in the same cycle in which
//   the pending result is transferred, so a stall costs no bubble.
//   Synchronous reset (rst_n low) empties the output register. The decode
//   ROM is constant and needs no clearing pass, so opcodes are accepted in
//   the first cycle after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module opcode_decoder_8bit_cpu_top import ocd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ocd_in_if.sink    in_chan,
  ocd_out_if.source out_chan
);

  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         in_xfer;
  decode_word_t rom_data;

  // The output register is free when empty or when it transfers this cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // The ROM is read only on an accepted opcode, so a stalled result holds.
  ocd_rom u_rom (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (in_chan.op_byte),
    .rd_data (rom_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.addr_mode   = rom_data.mode;
  assign out_chan.instr_bytes = rom_data.len;
  assign out_chan.op_class    = rom_data.cls;
  assign out_chan.is_illegal  = rom_data.illegal;

  // An accepted opcode always produces a result in the next cycle.
  `ASSERT_NEXT(a_xfer_gives_result, clk, rst_n, in_xfer, out_chan.valid)
  // Reset leaves no result pending.
  `ASSERT_NEXT(a_reset_empties, clk, 1'b1, !rst_n, !out_chan.valid)
  // The illegal flag agrees with the operation class.
  `ASSERT_SAME(a_illegal_flag, clk, rst_n, out_chan.valid,
               out_chan.is_illegal == (out_chan.op_class == OC_ILL))
  // Length never reads zero on a delivered result.
  `ASSERT_SAME(a_len_nonzero, clk, rst_n, out_chan.valid, out_chan.instr_bytes != 2'd0)

endmodule

### dv/tb_opcode_decoder_8bit_cpu_top.sv
// ----------------------------------------------------------------------------
// Testbench for the 8-bit CPU opcode decoder
// Drives opcode bytes into the decoder through its valid/ready input channel.
// It predicts the addressing mode, length, operation class and illegal flag of
// every transferred opcode from an independent per-column decode. Each result
// transfer is then checked in order against that prediction, while both sides
// of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_opcode_decoder_8bit_cpu_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ocd_pkg::*;

  localparam int unsigned CLK_HALF_NS    = 4;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned LONG_HOLD      = 60;
  localparam int unsigned SETTLE_CYCLES  = 4;

  // One predicted decode, tagged with the opcode that produced it so that a
  // mismatch report can name the offending byte.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    addr_mode_t         mode;
    logic [LEN_W-1:0]   len;
    op_class_t          cls;
    logic               illegal;
  } decode_result_t;

  // Column 0 and column 8 each hold one distinct operation per row.
  localparam op_class_t COL0_OPS [16] = '{
    OC_BRK, OC_BPL, OC_JSR, OC_BMI, OC_RTI, OC_BVC, OC_RTS, OC_BVS,
    OC_NOP, OC_BCC, OC_LDY, OC_BCS, OC_CPY, OC_BNE, OC_CPX, OC_BEQ
  };
  localparam op_class_t COL8_OPS [16] = '{
    OC_PHP, OC_CLC, OC_PLP, OC_SEC, OC_PHA, OC_CLI, OC_PLA, OC_SEI,
    OC_DEY, OC_TYA, OC_TAY, OC_CLV, OC_INY, OC_CLD, OC_INX, OC_SED
  };
  // The ALU group (columns 1, 5, 9, D) and the read-modify-write group
  // (columns 6 and E) select their operation by the upper three opcode bits.
  localparam op_class_t ALU_OPS [8] = '{
    OC_ORA, OC_AND, OC_EOR, OC_ADC, OC_STA, OC_LDA, OC_CMP, OC_SBC
  };
  localparam op_class_t RMW_OPS [8] = '{
    OC_ASLM, OC_ROLM, OC_LSRM, OC_RORM, OC_STX, OC_LDX, OC_DEC, OC_INC
  };
  localparam op_class_t ACC_SHIFT_OPS [4] = '{OC_ASLA, OC_ROLA, OC_LSRA, OC_RORA};

  logic clk;
  logic rst_n;

  ocd_in_if  in_chan ();
  ocd_out_if out_chan ();

  opcode_decoder_8bit_cpu_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Decodes that have been transferred in but whose result has not come out.
  decode_result_t pending_decodes[$];
  int unsigned    fail_count;
  // Random idling on both channels is switched on and off by the tests.
  bit             idle_on;
  // A request for one long receiver hold-off, picked up by the sink process.
  int unsigned    hold_request;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Addressing mode from the opcode column (low nibble) and row (high nibble).
  function automatic addr_mode_t mode_of(logic [OP_W-1:0] op);
    logic [3:0] col;
    logic [3:0] row;
    logic       odd_row;
    addr_mode_t m;
    col     = op[3:0];
    row     = op[7:4];
    odd_row = row[0];
    m       = AM_IMP;
    case (col)
      4'h0: begin
        if (row inside {4'h0, 4'h4, 4'h6}) m = AM_IMP;
        else if (row == 4'h2)              m = AM_ABS;
        else if (odd_row)                  m = AM_REL;
        else                               m = AM_IMM;
      end
      4'h1: m = odd_row ? AM_INDIDX : AM_IDXIND;
      4'h2: m = (row == 4'hA) ? AM_IMM : AM_IMP;
      4'h3: begin
        if (row == 4'hA)      m = AM_IDXIND;
        else if (row == 4'hB) m = AM_INDIDX;
      end
      4'h4, 4'h5: m = odd_row ? AM_ZPX : AM_ZP;
      4'h6: begin
        if (row inside {4'h9, 4'hB}) m = AM_ZPY;
        else                         m = odd_row ? AM_ZPX : AM_ZP;
      end
      4'h7: begin
        if (row == 4'hA)      m = AM_ZP;
        else if (row == 4'hB) m = AM_ZPY;
      end
      4'h9: begin
        if (row != 4'h8) m = odd_row ? AM_ABSY : AM_IMM;
      end
      4'hA: m = (!odd_row && row < 4'h8) ? AM_ACC : AM_IMP;
      4'hB: m = (row == 4'hE) ? AM_IMM : AM_IMP;
      4'hC: begin
        if (row == 4'h6) m = AM_IND;
        else             m = odd_row ? AM_ABSX : AM_ABS;
      end
      4'hD: m = odd_row ? AM_ABSX : AM_ABS;
      4'hE: begin
        if (row == 4'h9)      m = AM_IMP;
        else if (row == 4'hB) m = AM_ABSY;
        else                  m = odd_row ? AM_ABSX : AM_ABS;
      end
      4'hF: begin
        if (row == 4'hA)      m = AM_ABS;
        else if (row == 4'hB) m = AM_ABSY;
      end
      default: m = AM_IMP;
    endcase
    return m;
  endfunction

  // Operand bytes plus the opcode byte itself.
  function automatic logic [LEN_W-1:0] length_of(addr_mode_t m);
    case (m)
      AM_IMP, AM_ACC:                   return 2'd1;
      AM_ABS, AM_ABSX, AM_ABSY, AM_IND: return 2'd3;
      default:                          return 2'd2;
    endcase
  endfunction

  // Operation class, built column by column rather than as a flat table.
  function automatic op_class_t class_of(logic [OP_W-1:0] op);
    logic [3:0] col;
    logic [3:0] row;
    op_class_t  c;
    col = op[3:0];
    row = op[7:4];
    c   = OC_ILL;
    case (col)
      4'h0: c = COL0_OPS[row];
      4'h8: c = COL8_OPS[row];
      4'h1, 4'h5, 4'hD: c = ALU_OPS[row[3:1]];
      // STA immediate does not exist.
      4'h9: c = (row == 4'h8) ? OC_ILL : ALU_OPS[row[3:1]];
      4'h6, 4'hE: begin
        // STX absolute,Y does not exist.
        c = (op == 8'h9E) ? OC_ILL : RMW_OPS[row[3:1]];
      end
      4'hA: begin
        if (!row[0] && row < 4'h8) c = ACC_SHIFT_OPS[row[2:1]];
        else begin
          case (row)
            4'h8:    c = OC_TXA;
            4'h9:    c = OC_TXS;
            4'hA:    c = OC_TAX;
            4'hB:    c = OC_TSX;
            4'hC:    c = OC_DEX;
            default: c = OC_NOP;
          endcase
        end
      end
      4'h4, 4'hC: begin
        case (row)
          4'h2:       c = OC_BIT;
          4'h8:       c = OC_STY;
          4'h9:       c = (col == 4'h4) ? OC_STY : OC_ILL;
          4'hA, 4'hB: c = OC_LDY;
          4'hC:       c = OC_CPY;
          4'hE:       c = OC_CPX;
          4'h4, 4'h6: c = (col == 4'hC) ? OC_JMP : OC_NOP;
          default:    c = OC_NOP;
        endcase
      end
      4'h2: c = (row == 4'hA) ? OC_LDX : OC_ILL;
      4'h3, 4'h7, 4'hF: c = (row inside {4'hA, 4'hB}) ? OC_LAX : OC_ILL;
      4'hB: c = (row == 4'hE) ? OC_SBC : OC_ILL;
      default: c = OC_ILL;
    endcase
    return c;
  endfunction

  function automatic decode_result_t predict_decode(logic [OP_W-1:0] op);
    decode_result_t r;
    r.op      = op;
    r.mode    = mode_of(op);
    r.len     = length_of(r.mode);
    r.cls     = class_of(op);
    r.illegal = (r.cls == OC_ILL);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Failure reporting and result checking
  // --------------------------------------------------------------------------

  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [OP_W-1:0] op, int want, int got);
    if (want != got) begin
      log_failure($sformatf("opcode %02h %s: expected %0d, got %0d", op, name, want, got));
    end
  endtask

  // Every result transfer is compared against the oldest outstanding decode.
  // Sampling at the rising edge sees the values from before the edge, since
  // the block and the drivers below only change signals by nonblocking update.
  always @(posedge clk) begin
    decode_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_decodes.size() == 0) begin
        log_failure($sformatf("result with nothing pending: mode %0d len %0d class %0d ill %0b",
                              out_chan.addr_mode, out_chan.instr_bytes,
                              out_chan.op_class, out_chan.is_illegal));
      end else begin
        want = pending_decodes.pop_front();
        check_field("addr_mode", want.op, int'(want.mode), int'(out_chan.addr_mode));
        check_field("instr_bytes", want.op, int'(want.len), int'(out_chan.instr_bytes));
        check_field("op_class", want.op, int'(want.cls), int'(out_chan.op_class));
        check_field("is_illegal", want.op, int'(want.illegal), int'(out_chan.is_illegal));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink
  // --------------------------------------------------------------------------
  // Ready is decided once per cycle, so it never gets two updates in a step.
  // A long hold-off requested by a test takes precedence over random stalls,
  // and it is counted here so the sender keeps offering opcodes meanwhile.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_request != 0) begin
        stall_left   = hold_request - 1;
        hold_request = 0;
        out_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Opcode source
  // --------------------------------------------------------------------------
  // Offers one opcode and returns at the edge where it is transferred. Valid is
  // left high so a following call can present the next opcode in the same step
  // without a bubble; an optional random gap first drops valid.
  task automatic send_opcode(logic [OP_W-1:0] op);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.op_byte <= op;
    do @(posedge clk); while (!in_chan.ready);
    pending_decodes.push_back(predict_decode(op));
  endtask

  // Drops valid and waits until every pending result has been transferred.
  // The loop waits on the clock before it tests the queue, so valid never sees two updates in a step.
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_decodes.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Byte extremes, the unofficial opcodes that are decoded (LAX, SBC at EB and
  // NOPs in several modes), illegal opcodes in implicit and absolute,X mode, and
  // one representative of each remaining addressing mode.
  task automatic test_directed_opcodes();
    logic [OP_W-1:0] picks [$];
    picks = '{8'h00, 8'hFF, 8'h9C, 8'h82, 8'h89, 8'h9E, 8'h02,
              8'hA3, 8'hA7, 8'hAF, 8'hB3, 8'hB7, 8'hBF, 8'hEB,
              8'h80, 8'h04, 8'h14, 8'h0C, 8'h1C, 8'h1A,
              8'h6C, 8'h10, 8'hA2, 8'h0A, 8'h96, 8'h01};
    idle_on = 1'b1;
    foreach (picks[i]) send_opcode(picks[i]);
    wait_for_drain();
  endtask

  // Every opcode byte once, in order; this reaches every operation class and
  // every mode, including all illegal slots.
  task automatic test_opcode_sweep();
    idle_on = 1'b1;
    for (int op = 0; op < 256; op++) send_opcode(op[OP_W-1:0]);
    wait_for_drain();
  endtask

  // The receiver holds off for a long stretch while the sender keeps pushing
  // back to back, so the output register fills and input ready must drop.
  // Then the sender drains all pending results, sends again and drains again.
  task automatic test_output_backpressure();
    idle_on      = 1'b0;
    hold_request = LONG_HOLD;
    repeat (40) send_opcode(OP_W'($urandom_range(0, 255)));
    wait_for_drain();
    repeat (10) send_opcode(OP_W'($urandom_range(0, 255)));
    wait_for_drain();
  endtask

  // Random opcodes in chunks, with idling switched on for most chunks and off
  // for some, so gaps land on every phase of the handshake. Each chunk resends
  // one held opcode at random, so the same decode can recur across transfers.
  task automatic test_random_opcodes(int unsigned chunks);
    logic [OP_W-1:0] held_op;
    for (int unsigned k = 0; k < chunks; k++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      held_op = OP_W'($urandom_range(0, 255));
      for (int unsigned n = 0; n < 50; n++) begin
        if ($urandom_range(0, 9) == 0) send_opcode(held_op);
        else                           send_opcode(OP_W'($urandom_range(0, 255)));
      end
    end
    wait_for_drain();
  endtask

  // Closing stretch at full rate with neither side idling.
  task automatic test_full_rate();
    idle_on = 1'b0;
    repeat (200) send_opcode(OP_W'($urandom_range(0, 255)));
    wait_for_drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    fail_count   = 0;
    idle_on      = 1'b0;
    hold_request = 0;
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.op_byte <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_opcodes();
    test_opcode_sweep();
    test_output_backpressure();
    test_random_opcodes(29);
    test_full_rate();

    // Wait SETTLE_CYCLES so a stray result can appear after the last one.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run of about 2000 opcodes.
  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
